// ===== rtl/dmic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmic_pkg: shared types and helpers for the direct-mapped instruction cache
// Transfer payloads, result codes and address slicing helpers.
// ----------------------------------------------------------------------------
package dmic_pkg;

	localparam int LINES          = 256;
	localparam int WORDS_PER_LINE = 8;
	localparam int IDX_W          = $clog2(LINES);
	localparam int WSEL_W         = $clog2(WORDS_PER_LINE);
	localparam int TAG_W          = 19;
	localparam int LINE_W         = 32 * WORDS_PER_LINE;

	// request kinds
	localparam logic KIND_FETCH = 1'b0;
	localparam logic KIND_FILL  = 1'b1;

	typedef enum logic [1:0] {
		RK_DATA  = 2'd0,
		RK_FILL  = 2'd1,
		RK_ERROR = 2'd2
	} rkind_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] address;
		logic [31:0] fill_data;
		logic        fill_error;
	} req_t;

	typedef struct packed {
		rkind_t      result_kind;
		logic [15:0] fetch_data;
		logic [28:0] fill_address;
		logic        was_hit;
	} rsp_t;

	// line index: bits 11..5, top bit from bit 12 or bit 25
	function automatic logic [IDX_W-1:0] line_of(input logic [31:0] a, input logic mode);
		line_of = {(mode ? a[25] : a[12]), a[11:5]};
	endfunction

	function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] a);
		tag_of = a[28:10];
	endfunction

	function automatic logic [28:0] line_addr(input logic [31:0] a);
		line_addr = {a[28:5], 5'b0};
	endfunction

endpackage

// ===== rtl/direct_mapped_instruction_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_instruction_cache
// 256-line direct-mapped cache answering 16-bit fetches, with line fills
// streamed in as eight longwords and split fetches on odd addresses.
// ----------------------------------------------------------------------------
//
//  channel | signals                        | direction | payload
//  --------+--------------------------------+-----------+-------------------
//  req     | req_valid, req_ready, req      | in        | fetch or fill word
//  rsp     | rsp_valid, rsp_ready, rsp      | out       | data / fill / error
//  cfg     | cfg_valid, cfg_ready, cfg_data | in        | index_mode
//
//  One request is taken per cycle while the response side is not stalled.
//  Tag and line memories are read at the accepting edge into the input
//  stage, which decides hit/miss and loads the response register.
//  A stalled response holds the input stage; the input stage still takes a
//  new request when its occupant moves to the output register that cycle.
//  Reset clears the valid bits and control state at once; no clearing pass.
//
module direct_mapped_instruction_cache (
	input  logic            clk,
	input  logic            arst_n,

	input  logic            req_valid,
	output logic            req_ready,
	input  dmic_pkg::req_t  req,

	output logic            rsp_valid,
	input  logic            rsp_ready,
	output dmic_pkg::rsp_t  rsp,

	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_data
);

	localparam int IDX_W  = dmic_pkg::IDX_W;
	localparam int TAG_W  = dmic_pkg::TAG_W;
	localparam int LINE_W = dmic_pkg::LINE_W;
	localparam int WPL    = dmic_pkg::WORDS_PER_LINE;
	localparam int WSEL_W = dmic_pkg::WSEL_W;
	localparam logic [WSEL_W-1:0] LAST_WORD = WSEL_W'(WPL - 1);

	// ------------------------------------------------------------------
	// storage
	// ------------------------------------------------------------------
	logic [LINE_W-1:0] line_mem [dmic_pkg::LINES];
	logic [TAG_W-1:0]  tag_mem  [dmic_pkg::LINES];
	logic [dmic_pkg::LINES-1:0] valid_q;
	logic [31:0] stage_q [WPL];

	// cache control state
	logic              mode_q;
	logic              fill_pend_q, fill_pend_d;
	logic [WSEL_W-1:0] fill_cnt_q, fill_cnt_d;
	logic [31:0]       pend_addr_q, pend_addr_d;
	logic              phase_q, phase_d;
	logic [7:0]        low_byte_q, low_byte_d;
	logic              any_miss_q, any_miss_d;

	// input stage
	logic               vld_s1;
	dmic_pkg::req_t     req_s1;
	logic [LINE_W-1:0]  rowa_s1, rowb_s1;
	logic [TAG_W-1:0]   taga_s1, tagb_s1;
	logic [IDX_W-1:0]   idxa_s1, idxb_s1;
	// line written at the same edge this stage was loaded (read was stale)
	logic               fwd_vld_s1;
	logic [IDX_W-1:0]   fwd_idx_s1;
	logic [TAG_W-1:0]   fwd_tag_s1;

	// output register
	logic               rsp_vld_q;
	dmic_pkg::rsp_t     rsp_q;

	logic req_xfer, go_s1;
	logic [31:0]       addr_b_src;
	logic [IDX_W-1:0]  rd_idx_a, rd_idx_b;

	logic [LINE_W-1:0] stage_row, new_row, rowa_eff, rowb_eff;
	logic [TAG_W-1:0]  taga_eff, tagb_eff, wr_tag;
	logic [IDX_W-1:0]  wr_idx;
	logic [31:0]       base_addr, next_addr;
	logic              hit_a, hit_b, hit_b_fill;
	logic [7:0]        lo_byte, hi_byte;
	logic              stage_we, row_we, res_vld;
	dmic_pkg::rsp_t    res;

	function automatic logic [31:0] word_sel(input logic [LINE_W-1:0] row,
			input logic [31:0] a);
		word_sel = row[{a[4:2], 5'b0} +: 32];
	endfunction

	function automatic logic [7:0] byte_sel(input logic [31:0] wd, input logic [1:0] b);
		byte_sel = wd[{b, 3'b0} +: 8];
	endfunction

	function automatic logic [15:0] half_sel(input logic [31:0] wd, input logic b1);
		half_sel = wd[{b1, 4'b0} +: 16];
	endfunction

	// ------------------------------------------------------------------
	// handshakes
	// ------------------------------------------------------------------
	assign go_s1     = vld_s1 && (!rsp_vld_q || rsp_ready);
	assign req_ready = !vld_s1 || go_s1;
	assign req_xfer  = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// Fill words only use port B at the eighth word, by which time the
	// pending address has been stable for several transfers.
	assign addr_b_src = (req.kind == dmic_pkg::KIND_FILL) ? pend_addr_q : req.address;
	assign rd_idx_a   = dmic_pkg::line_of(req.address, mode_q);
	assign rd_idx_b   = dmic_pkg::line_of(addr_b_src + 32'd1, mode_q);

	// ------------------------------------------------------------------
	// memories: one row write, two registered reads
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (row_we) begin
			line_mem[wr_idx] <= new_row;
			tag_mem[wr_idx]  <= wr_tag;
		end
		if (req_xfer) begin
			rowa_s1 <= line_mem[rd_idx_a];
			rowb_s1 <= line_mem[rd_idx_b];
			taga_s1 <= tag_mem[rd_idx_a];
			tagb_s1 <= tag_mem[rd_idx_b];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_we) begin
			stage_q[fill_cnt_q] <= req_s1.fill_data;
		end
	end

	// ------------------------------------------------------------------
	// input stage and forwarding
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			fwd_vld_s1 <= 1'b0;
		end else begin
			if (req_xfer) begin
				vld_s1     <= 1'b1;
				fwd_vld_s1 <= row_we;
			end else if (go_s1) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_s1     <= req;
			idxa_s1    <= rd_idx_a;
			idxb_s1    <= rd_idx_b;
			fwd_idx_s1 <= wr_idx;
			fwd_tag_s1 <= wr_tag;
		end
	end

	// ------------------------------------------------------------------
	// hit check, fill sequencing and response build
	// ------------------------------------------------------------------
	always_comb begin
		for (int w = 0; w < WPL; w++) begin
			stage_row[w*32 +: 32] = stage_q[w];
		end
	end

	// the row being completed: seven staged words plus the incoming one
	assign new_row = {req_s1.fill_data, stage_row[LINE_W-33:0]};
	assign wr_idx  = dmic_pkg::line_of(pend_addr_q, mode_q);
	assign wr_tag  = dmic_pkg::tag_of(pend_addr_q);

	// stage still holds the row that was written as this item was read
	assign rowa_eff = (fwd_vld_s1 && fwd_idx_s1 == idxa_s1) ? stage_row : rowa_s1;
	assign rowb_eff = (fwd_vld_s1 && fwd_idx_s1 == idxb_s1) ? stage_row : rowb_s1;
	assign taga_eff = (fwd_vld_s1 && fwd_idx_s1 == idxa_s1) ? fwd_tag_s1 : taga_s1;
	assign tagb_eff = (fwd_vld_s1 && fwd_idx_s1 == idxb_s1) ? fwd_tag_s1 : tagb_s1;

	assign base_addr = (req_s1.kind == dmic_pkg::KIND_FILL) ? pend_addr_q : req_s1.address;
	assign next_addr = base_addr + 32'd1;

	assign hit_a = valid_q[idxa_s1] && taga_eff == dmic_pkg::tag_of(req_s1.address);
	assign hit_b = valid_q[idxb_s1] && tagb_eff == dmic_pkg::tag_of(next_addr);
	// after a fill, the just-written line counts as present
	assign hit_b_fill = (idxb_s1 == wr_idx) ? (wr_tag == dmic_pkg::tag_of(next_addr)) : hit_b;

	always_comb begin
		fill_pend_d = fill_pend_q;
		fill_cnt_d  = fill_cnt_q;
		pend_addr_d = pend_addr_q;
		phase_d     = phase_q;
		low_byte_d  = low_byte_q;
		any_miss_d  = any_miss_q;
		stage_we    = 1'b0;
		row_we      = 1'b0;
		res_vld     = 1'b0;
		res         = '0;
		lo_byte     = '0;
		hi_byte     = '0;

		if (go_s1) begin
			if (req_s1.kind == dmic_pkg::KIND_FETCH) begin
				if (!fill_pend_q) begin
					res_vld     = 1'b1;
					pend_addr_d = req_s1.address;
					phase_d     = 1'b0;
					any_miss_d  = 1'b0;
					if (!hit_a) begin
						fill_pend_d      = 1'b1;
						fill_cnt_d       = '0;
						any_miss_d       = 1'b1;
						res.result_kind  = dmic_pkg::RK_FILL;
						res.fill_address = dmic_pkg::line_addr(req_s1.address);
					end else if (!req_s1.address[0]) begin
						res.result_kind = dmic_pkg::RK_DATA;
						res.fetch_data  = half_sel(word_sel(rowa_eff, req_s1.address),
							req_s1.address[1]);
						res.was_hit     = 1'b1;
					end else begin
						// odd address: two byte reads, second may be in next line
						lo_byte     = byte_sel(word_sel(rowa_eff, req_s1.address),
							req_s1.address[1:0]);
						pend_addr_d = next_addr;
						if (!hit_b) begin
							low_byte_d       = lo_byte;
							phase_d          = 1'b1;
							fill_pend_d      = 1'b1;
							fill_cnt_d       = '0;
							any_miss_d       = 1'b1;
							res.result_kind  = dmic_pkg::RK_FILL;
							res.fill_address = dmic_pkg::line_addr(next_addr);
						end else begin
							hi_byte         = byte_sel(word_sel(rowb_eff, next_addr),
								next_addr[1:0]);
							res.result_kind = dmic_pkg::RK_DATA;
							res.fetch_data  = {hi_byte, lo_byte};
							res.was_hit     = 1'b1;
						end
					end
				end
			end else if (fill_pend_q) begin
				if (req_s1.fill_error) begin
					// abort: line untouched, staged words dropped
					fill_pend_d      = 1'b0;
					fill_cnt_d       = '0;
					phase_d          = 1'b0;
					res_vld          = 1'b1;
					res.result_kind  = dmic_pkg::RK_ERROR;
					res.fill_address = dmic_pkg::line_addr(pend_addr_q);
				end else begin
					stage_we = 1'b1;
					if (fill_cnt_q != LAST_WORD) begin
						fill_cnt_d = fill_cnt_q + 1'b1;
					end else begin
						row_we      = 1'b1;
						fill_pend_d = 1'b0;
						fill_cnt_d  = '0;
						res_vld     = 1'b1;
						if (!phase_q) begin
							if (!pend_addr_q[0]) begin
								res.result_kind = dmic_pkg::RK_DATA;
								res.fetch_data  = half_sel(word_sel(new_row, pend_addr_q),
									pend_addr_q[1]);
								res.was_hit     = !any_miss_q;
							end else begin
								lo_byte     = byte_sel(word_sel(new_row, pend_addr_q),
									pend_addr_q[1:0]);
								pend_addr_d = next_addr;
								if (!hit_b_fill) begin
									low_byte_d       = lo_byte;
									phase_d          = 1'b1;
									fill_pend_d      = 1'b1;
									any_miss_d       = 1'b1;
									res.result_kind  = dmic_pkg::RK_FILL;
									res.fill_address = dmic_pkg::line_addr(next_addr);
								end else begin
									if (idxb_s1 == wr_idx) begin
										hi_byte = byte_sel(word_sel(new_row, next_addr),
											next_addr[1:0]);
									end else begin
										hi_byte = byte_sel(word_sel(rowb_eff, next_addr),
											next_addr[1:0]);
									end
									phase_d         = 1'b0;
									res.result_kind = dmic_pkg::RK_DATA;
									res.fetch_data  = {hi_byte, lo_byte};
									res.was_hit     = !any_miss_q;
								end
							end
						end else begin
							// second byte of a split fetch
							hi_byte         = byte_sel(word_sel(new_row, pend_addr_q),
								pend_addr_q[1:0]);
							phase_d         = 1'b0;
							res.result_kind = dmic_pkg::RK_DATA;
							res.fetch_data  = {hi_byte, low_byte_q};
							res.was_hit     = !any_miss_q;
						end
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// state registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			valid_q     <= '0;
			fill_pend_q <= 1'b0;
			fill_cnt_q  <= '0;
			pend_addr_q <= '0;
			phase_q     <= 1'b0;
			low_byte_q  <= '0;
			any_miss_q  <= 1'b0;
			rsp_vld_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (row_we) begin
				valid_q[wr_idx] <= 1'b1;
			end
			fill_pend_q <= fill_pend_d;
			fill_cnt_q  <= fill_cnt_d;
			pend_addr_q <= pend_addr_d;
			phase_q     <= phase_d;
			low_byte_q  <= low_byte_d;
			any_miss_q  <= any_miss_d;
			if (go_s1) begin
				rsp_vld_q <= res_vld;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && res_vld) begin
			rsp_q <= res;
		end
	end

endmodule

// ===== test/tb_direct_mapped_instruction_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_direct_mapped_instruction_cache: self-checking bench for the I-cache
// Drives fetches and fill longwords over the request channel and checks every
// response against an in-bench cache model. The stimulus is planned up front
// with a second copy of that model, so each miss gets exactly the fill beats
// it needs. Both channels stall at random. index_mode is rewritten between
// phases, once the cache has gone quiet.
// ----------------------------------------------------------------------------
module tb_direct_mapped_instruction_cache;

	localparam int ITEMS       = 650;  // counted items (ignored ones excluded)
	localparam int IDLE_PCT    = 22;   // random idle rate on both sides
	localparam int SETTLE      = 4;    // quiet cycles before a mode write
	localparam int STALL_LIMIT = 2000; // cycles without any transfer
	localparam int POOL        = 16;   // line bases that fetches reuse
	localparam int ERR_PCT     = 6;    // chance that a line fill is aborted

	typedef enum logic [1:0] {
		SEQ_REQ,   // one request transfer
		SEQ_MODE,  // index_mode write once the cache is quiet
		SEQ_DRAIN  // hold off until every response is back
	} seq_op_t;

	typedef struct packed {
		seq_op_t         op;
		dmic_pkg::req_t  req;
		logic            mode;
		logic            calm;  // no idling on either side while set
	} seq_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic req_valid = 1'b0;
	logic req_ready;
	dmic_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	dmic_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	direct_mapped_instruction_cache i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Cache model. Copy 0 tracks the DUT at run time (fed by the monitor),
	// copy 1 is run by the planner while the stimulus is built.
	// ------------------------------------------------------------------
	logic [18:0] tag_mirror [2][dmic_pkg::LINES];
	logic        line_ok    [2][dmic_pkg::LINES];
	logic [31:0] line_data  [2][dmic_pkg::LINES*dmic_pkg::WORDS_PER_LINE];
	logic [31:0] stage_buf  [2][dmic_pkg::WORDS_PER_LINE];
	logic        filling    [2];
	logic [2:0]  fill_idx   [2];
	logic [31:0] fetch_addr [2];
	logic        second_byte[2];
	logic [7:0]  saved_low  [2];
	logic        missed     [2];
	logic        mode       [2];

	function automatic logic [7:0] slot_for(input bit p, input logic [31:0] a);
		return {(mode[p] ? a[25] : a[12]), a[11:5]};
	endfunction

	function automatic logic [28:0] base_for(input logic [31:0] a);
		return {a[28:5], 5'b0};
	endfunction

	function automatic bit resident(input bit p, input logic [31:0] a);
		logic [7:0] s;
		s = slot_for(p, a);
		return line_ok[p][s] && tag_mirror[p][s] == a[28:10];
	endfunction

	// longword holding byte a, shifted so that byte sits in bits 7..0
	function automatic logic [31:0] word_for(input bit p, input logic [31:0] a);
		return line_data[p][{slot_for(p, a), a[4:2]}] >> {a[1:0], 3'b000};
	endfunction

	function automatic dmic_pkg::rsp_t ask_fill(input bit p);
		dmic_pkg::rsp_t r;
		r = '0;
		filling[p] = 1'b1;
		fill_idx[p] = 3'd0;
		missed[p] = 1'b1;
		r.result_kind = dmic_pkg::RK_FILL;
		r.fill_address = base_for(fetch_addr[p]);
		return r;
	endfunction

	// take the pending fetch as far as the resident lines allow
	function automatic dmic_pkg::rsp_t serve_fetch(input bit p);
		dmic_pkg::rsp_t r;
		logic [31:0] a;
		logic [31:0] w;
		r = '0;
		a = fetch_addr[p];
		if (!second_byte[p]) begin
			if (!resident(p, a))
				return ask_fill(p);
			w = word_for(p, a);
			if (!a[0]) begin
				r.result_kind = dmic_pkg::RK_DATA;
				r.fetch_data = w[15:0];
				r.was_hit = !missed[p];
				return r;
			end
			// odd fetch: keep the low byte, go after the next one
			saved_low[p] = w[7:0];
			second_byte[p] = 1'b1;
			a = a + 32'd1;
			fetch_addr[p] = a;
		end
		if (!resident(p, a))
			return ask_fill(p);
		w = word_for(p, a);
		second_byte[p] = 1'b0;
		r.result_kind = dmic_pkg::RK_DATA;
		r.fetch_data = {w[7:0], saved_low[p]};
		r.was_hit = !missed[p];
		return r;
	endfunction

	// one request transfer; returns 1 when it yields a response
	function automatic bit cache_step(input bit p, input dmic_pkg::req_t q,
			output dmic_pkg::rsp_t r);
		logic [7:0] s;
		r = '0;
		if (q.kind == dmic_pkg::KIND_FETCH) begin
			if (filling[p])
				return 1'b0;
			fetch_addr[p] = q.address;
			second_byte[p] = 1'b0;
			missed[p] = 1'b0;
			r = serve_fetch(p);
			return 1'b1;
		end
		if (!filling[p])
			return 1'b0;
		if (q.fill_error) begin
			filling[p] = 1'b0;
			fill_idx[p] = 3'd0;
			second_byte[p] = 1'b0;
			r.result_kind = dmic_pkg::RK_ERROR;
			r.fill_address = base_for(fetch_addr[p]);
			return 1'b1;
		end
		stage_buf[p][fill_idx[p]] = q.fill_data;
		if (fill_idx[p] != 3'd7) begin
			fill_idx[p] = fill_idx[p] + 3'd1;
			return 1'b0;
		end
		// eighth longword: commit the line, index taken with the current mode
		s = slot_for(p, fetch_addr[p]);
		for (int i = 0; i < dmic_pkg::WORDS_PER_LINE; i++)
			line_data[p][{s, i[2:0]}] = stage_buf[p][i];
		tag_mirror[p][s] = fetch_addr[p][28:10];
		line_ok[p][s] = 1'b1;
		filling[p] = 1'b0;
		fill_idx[p] = 3'd0;
		r = serve_fetch(p);
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus planning
	// ------------------------------------------------------------------
	seq_t            plan_q[$];
	dmic_pkg::rsp_t  expected_q[$];
	logic [31:0]     addr_pool[POOL];
	int              n_items;
	logic            calm_gen;

	function automatic dmic_pkg::req_t fetch_req(input logic [31:0] a);
		dmic_pkg::req_t q;
		q.kind = dmic_pkg::KIND_FETCH;
		q.address = a;
		q.fill_data = $urandom();   // don't care on a fetch, toggled anyway
		q.fill_error = 1'($urandom_range(1));
		return q;
	endfunction

	function automatic dmic_pkg::req_t fill_req(input logic [31:0] d, input logic err);
		dmic_pkg::req_t q;
		q.kind = dmic_pkg::KIND_FILL;
		q.address = $urandom();
		q.fill_data = d;
		q.fill_error = err;
		return q;
	endfunction

	function automatic logic [31:0] fill_word();
		case ($urandom_range(15))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	function automatic void plan_req(input dmic_pkg::req_t q, output bit made,
			output dmic_pkg::rsp_t r);
		seq_t e;
		bit counted;
		counted = (q.kind == dmic_pkg::KIND_FETCH) ? !filling[1] : filling[1];
		made = cache_step(1'b1, q, r);
		e.op = SEQ_REQ;
		e.req = q;
		e.mode = 1'b0;
		e.calm = calm_gen;
		plan_q.push_back(e);
		if (counted)
			n_items++;
	endfunction

	function automatic void plan_ctl(input seq_op_t op, input logic m);
		seq_t e;
		e = '0;
		e.op = op;
		e.mode = m;
		e.calm = calm_gen;
		if (op == SEQ_MODE)
			mode[1] = m;
		plan_q.push_back(e);
	endfunction

	// one fetch plus every fill it needs (two on a line-crossing odd fetch)
	function automatic void plan_fetch(input logic [31:0] a, input int err_pct);
		bit made;
		dmic_pkg::rsp_t r;
		int bad;
		plan_req(fetch_req(a), made, r);
		while (made && r.result_kind == dmic_pkg::RK_FILL) begin
			bad = ($urandom_range(99) < err_pct) ? $urandom_range(7) :
				dmic_pkg::WORDS_PER_LINE;
			// a fetch in the middle of a fill is dropped by the cache
			if ($urandom_range(99) < 5)
				plan_req(fetch_req($urandom()), made, r);
			made = 1'b0;
			for (int k = 0; k < dmic_pkg::WORDS_PER_LINE && !made; k++)
				plan_req(fill_req(fill_word(), k == bad), made, r);
		end
	endfunction

	function automatic logic [31:0] pick_addr();
		logic [31:0] a;
		if ($urandom_range(99) < 12)
			return $urandom();
		a = addr_pool[$urandom_range(POOL - 1)];
		a[4:0] = ($urandom_range(9) == 0) ? 5'h1f : 5'($urandom_range(31));
		a[31:29] = 3'($urandom_range(7));
		return a;
	endfunction

	// ------------------------------------------------------------------
	// Driver: inputs change on the falling edge only
	// ------------------------------------------------------------------
	logic req_done = 1'b0;  // request transfer at the last rising edge
	logic cfg_done = 1'b0;  // mode write at the last rising edge
	logic calm_now = 1'b0;
	int   quiet = 0;        // rising edges with nothing in flight

	always @(negedge clk) begin
		logic nv;
		logic ncv;
		logic ncd;
		dmic_pkg::req_t np;
		if (arst_n) begin
			nv = req_valid && !req_done;
			np = req;
			ncv = cfg_valid && !cfg_done;
			ncd = cfg_data;
			if (!nv && !ncv && plan_q.size() != 0) begin
				case (plan_q[0].op)
					SEQ_REQ: begin
						if (plan_q[0].calm || $urandom_range(99) >= IDLE_PCT) begin
							nv = 1'b1;
							np = plan_q[0].req;
							calm_now <= plan_q[0].calm;
							void'(plan_q.pop_front());
						end
					end
					SEQ_MODE: begin
						// written only once every response is back and the pipe is empty
						if (quiet >= SETTLE) begin
							ncv = 1'b1;
							ncd = plan_q[0].mode;
							void'(plan_q.pop_front());
						end
					end
					default: begin
						if (quiet >= SETTLE)
							void'(plan_q.pop_front());
					end
				endcase
			end
			req_valid <= nv;
			req <= np;
			cfg_valid <= ncv;
			cfg_data <= ncd;
			rsp_ready <= calm_now || $urandom_range(99) >= IDLE_PCT;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: transfers sampled on the rising edge
	// ------------------------------------------------------------------
	int mismatches = 0;
	int stuck = 0;

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (want !== seen) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		dmic_pkg::rsp_t want;
		dmic_pkg::rsp_t r;
		bit made;
		if (arst_n) begin
			req_done <= req_valid && req_ready;
			cfg_done <= cfg_valid && cfg_ready;

			// response transfers first: nothing answers in the same cycle
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected response: kind %0d data 0x%0h line 0x%0h hit %0b",
						rsp.result_kind, rsp.fetch_data, rsp.fill_address, rsp.was_hit);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					check_field("result_kind", 32'(want.result_kind),
						32'(rsp.result_kind));
					check_field("fetch_data", 32'(want.fetch_data), 32'(rsp.fetch_data));
					check_field("fill_address", 32'(want.fill_address),
						32'(rsp.fill_address));
					check_field("was_hit", 32'(want.was_hit), 32'(rsp.was_hit));
				end
			end
			if (req_valid && req_ready) begin
				made = cache_step(1'b0, req, r);
				if (made)
					expected_q.push_back(r);
			end
			if (cfg_valid && cfg_ready)
				mode[0] = cfg_data;

			if (expected_q.size() == 0 && !rsp_valid && !req_valid && !cfg_valid)
				quiet <= quiet + 1;
			else
				quiet <= 0;

			// watchdog on cycles with no transfer at all
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
					(cfg_valid && cfg_ready)) begin
				stuck <= 0;
			end else if (stuck >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				stuck <= stuck + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Plan the whole run, release reset, wait for the end
	// ------------------------------------------------------------------
	initial begin
		bit made;
		dmic_pkg::rsp_t r;
		int next_mode_at;
		logic next_mode;
		bit drained;

		for (int p = 0; p < 2; p++) begin
			for (int i = 0; i < dmic_pkg::LINES; i++) begin
				tag_mirror[p][i] = '0;
				line_ok[p][i] = 1'b0;
			end
			filling[p] = 1'b0;
			fill_idx[p] = 3'd0;
			fetch_addr[p] = '0;
			second_byte[p] = 1'b0;
			saved_low[p] = '0;
			missed[p] = 1'b0;
			mode[p] = 1'b0;
		end
		n_items = 0;
		calm_gen = 1'b0;

		// some bases share an index with another base but carry another tag
		for (int i = 0; i < POOL; i++) begin
			if (i > 0 && $urandom_range(2) == 0)
				addr_pool[i] = addr_pool[i-1] ^ (32'h1 << $urandom_range(28, 13));
			else
				addr_pool[i] = $urandom();
		end

		// directed part, index_mode 0 out of reset
		plan_req(fill_req(32'hffff_ffff, 1'b0), made, r);   // stray beat, dropped
		plan_req(fetch_req(32'hffff_ffff), made, r);        // top of memory, miss
		plan_req(fetch_req(32'h0000_0000), made, r);        // dropped, fill pending
		for (int k = 0; k < dmic_pkg::WORDS_PER_LINE; k++)
			plan_req(fill_req((k == 0) ? 32'hffff_ffff : (k == 1) ? 32'h0 : fill_word(),
				1'b0), made, r);                           // second byte wraps to 0: miss
		plan_req(fill_req(32'h0, 1'b1), made, r);           // abort the second fill
		plan_req(fetch_req(32'hffff_fffe), made, r);        // even hit, last halfword
		plan_req(fetch_req(32'h1fff_fffd), made, r);        // odd hit inside the line
		plan_ctl(SEQ_MODE, 1'b1);
		plan_fetch(32'h0200_0001, 0);                        // index top bit from bit 25
		plan_fetch(32'he000_001f, 0);                        // odd, crosses into next line
		plan_fetch(32'h1fff_fffe, 0);

		// random part
		next_mode_at = 160;
		next_mode = 1'b0;
		drained = 1'b0;
		while (n_items < ITEMS) begin
			if (n_items >= next_mode_at) begin
				plan_ctl(SEQ_MODE, next_mode);
				next_mode = !next_mode;
				next_mode_at += 160;
			end
			if (!drained && n_items >= 240) begin
				plan_ctl(SEQ_DRAIN, 1'b0);
				drained = 1'b1;
			end
			calm_gen = n_items >= 350 && n_items < 470;
			if ($urandom_range(99) < 6)
				plan_req(fill_req($urandom(), 1'($urandom_range(1))), made, r);
			else
				plan_fetch(pick_addr(), ERR_PCT);
		end

		// model copy 0 starts from reset as well
		mode[0] = 1'b0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		while (plan_q.size() != 0 || req_valid || cfg_valid || expected_q.size() != 0)
			@(negedge clk);
		repeat (2 * SETTLE) @(negedge clk);

		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/dmic_pkg.sv
rtl/direct_mapped_instruction_cache.sv
test/tb_direct_mapped_instruction_cache.sv
